@@ sv/ring_cadence_driver_core_assert.svh @@
// Assertion macros for the ring cadence driver; empty under synthesis.
`ifndef RING_CADENCE_DRIVER_CORE_ASSERT_SVH
`define RING_CADENCE_DRIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCD_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rcd assertion failed");
`define RCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcd assertion failed");
`define RCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcd assertion failed");
`else
`define RCD_ASSERT(lbl, clk, rst, expr)
`define RCD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RCD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/rcd_pkg.sv @@
// Shared types, codes and helper functions of the ring cadence driver.
package rcd_pkg;

   localparam int MAX_SEGMENTS = 8;

   localparam int REQ_TYPE_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int SEG_W      = 16;
   localparam int CNT_W      = 4;
   localparam int BYTE_W     = 8;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEG_LO     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEG_HI     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEG_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_CNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CYCLE_MS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_DND = 3'd6;

   localparam logic [CNT_W-1:0] MAX_SEG_N = CNT_W'(MAX_SEGMENTS);

   typedef struct packed {
      logic [CSR_DATA_W-1:0] seg_lo;
      logic [CSR_DATA_W-1:0] seg_hi;
      logic [CNT_W-1:0]      seg_count;
      logic [BYTE_W-1:0]     repeat_count;
      logic                  pattern_mode;
      logic [BYTE_W-1:0]     cycle_ms;
      logic                  ignore_dnd;
   } cfg_type;

   // Duration of one segment, four 16-bit fields per word.
   function automatic logic [SEG_W-1:0] seg_duration(
      input logic [2:0] idx, input logic [CSR_DATA_W-1:0] lo,
      input logic [CSR_DATA_W-1:0] hi);
      logic [CSR_DATA_W-1:0] w;
      w = idx[2] ? hi : lo;
      return w[{idx[1:0], 4'b0000} +: SEG_W];
   endfunction

   // Zero counts as one, anything past the limit as the limit.
   function automatic logic [CNT_W-1:0] used_segments(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (r == '0) r = CNT_W'(1);
      if (r > MAX_SEG_N) r = MAX_SEG_N;
      return r;
   endfunction

endpackage

@@ sv/rcd_intf.sv @@
// Channel interfaces: request, response and register write.
interface rcd_req_if;
   logic                             valid;
   logic                             ready;
   logic [rcd_pkg::REQ_TYPE_W-1:0]   req_type;
   logic                             dnd;
   modport source (output valid, output req_type, output dnd, input ready);
   modport sink (input valid, input req_type, input dnd, output ready);
endinterface

interface rcd_rsp_if;
   logic valid;
   logic ready;
   logic drive_a;
   logic drive_b;
   logic bridge_enable;
   logic ringing;
   logic ring_done;
   modport source (output valid, output drive_a, output drive_b, output bridge_enable,
                   output ringing, output ring_done, input ready);
   modport sink (input valid, input drive_a, input drive_b, input bridge_enable,
                 input ringing, input ring_done, output ready);
endinterface

interface rcd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rcd_pkg::CSR_IDX_W-1:0]    index;
   logic [rcd_pkg::CSR_DATA_W-1:0]   wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ sv/rcd_csr.sv @@
// Configuration register bank of the ring cadence driver.
module rcd_csr (
   input  logic            clock,
   input  logic            reset,
   rcd_csr_if.sink         csr_ch,
   output rcd_pkg::cfg_type cfg
);
   import rcd_pkg::*;

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_lo       <= CSR_DATA_W'(2000);
         cfg_ff.seg_hi       <= '0;
         cfg_ff.seg_count    <= CNT_W'(1);
         cfg_ff.repeat_count <= BYTE_W'(1);
         cfg_ff.pattern_mode <= 1'b0;
         cfg_ff.cycle_ms     <= BYTE_W'(30);
         cfg_ff.ignore_dnd   <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SEG_LO:     cfg_ff.seg_lo       <= csr_ch.wdata;
            REG_SEG_HI:     cfg_ff.seg_hi       <= csr_ch.wdata;
            REG_SEG_COUNT:  cfg_ff.seg_count    <= csr_ch.wdata[CNT_W-1:0];
            REG_REPEAT_CNT: cfg_ff.repeat_count <= csr_ch.wdata[BYTE_W-1:0];
            REG_PATTERN:    cfg_ff.pattern_mode <= csr_ch.wdata[0];
            REG_CYCLE_MS:   cfg_ff.cycle_ms     <= csr_ch.wdata[BYTE_W-1:0];
            REG_IGNORE_DND: cfg_ff.ignore_dnd   <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

endmodule

@@ sv/rcd_engine.sv @@
// Cadence engine: request register, ring state update, response register.
module rcd_engine (
   input  logic            clock,
   input  logic            reset,
   input  rcd_pkg::cfg_type cfg,
   rcd_req_if.sink         req_ch,
   rcd_rsp_if.source       rsp_ch
);
   import rcd_pkg::*;
   `include "ring_cadence_driver_core_assert.svh"

   // request stage
   logic                  in_valid_ff;
   logic [REQ_TYPE_W-1:0] in_type_ff;
   logic                  in_dnd_ff;

   // ring state
   logic             active_ff, active_in;
   logic [CNT_W-1:0] seg_index_ff, seg_index_in;
   logic [BYTE_W-1:0] repeat_done_ff, repeat_done_in;
   logic [SEG_W-1:0] seg_elapsed_ff, seg_elapsed_in;
   logic [BYTE_W-1:0] flip_elapsed_ff, flip_elapsed_in;
   logic             polarity_ff, polarity_in;
   logic             pending_ff, pending_in;
   logic             lvl_a_ff, lvl_a_in;
   logic             lvl_b_ff, lvl_b_in;
   logic             done_in;

   // response stage
   logic out_valid_ff;
   logic drive_a_ff, drive_b_ff, ringing_ff, ring_done_ff;

   logic             out_load;
   logic [CNT_W-1:0] n_segs;
   logic             ring;
   logic             flip_go;

   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || out_load;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.drive_a       = drive_a_ff;
   assign rsp_ch.drive_b       = drive_b_ff;
   assign rsp_ch.bridge_enable = ringing_ff;
   assign rsp_ch.ringing       = ringing_ff;
   assign rsp_ch.ring_done     = ring_done_ff;

   assign n_segs = used_segments(cfg.seg_count);

   always_comb begin
      active_in       = active_ff;
      seg_index_in    = seg_index_ff;
      repeat_done_in  = repeat_done_ff;
      seg_elapsed_in  = seg_elapsed_ff;
      flip_elapsed_in = flip_elapsed_ff;
      polarity_in     = polarity_ff;
      pending_in      = pending_ff;
      lvl_a_in        = lvl_a_ff;
      lvl_b_in        = lvl_b_ff;
      done_in         = 1'b0;
      ring            = 1'b0;
      flip_go         = 1'b0;
      case (in_type_ff)
         REQ_TICK: begin
            if (active_ff) begin
               if (seg_elapsed_ff != '1) seg_elapsed_in = seg_elapsed_ff + SEG_W'(1);
               if (flip_elapsed_ff != '1) flip_elapsed_in = flip_elapsed_ff + BYTE_W'(1);
               // first period is measured from start, flip already happened
               if (pending_ff && (flip_elapsed_in >= cfg.cycle_ms)) begin
                  pending_in      = 1'b0;
                  flip_elapsed_in = flip_elapsed_in - cfg.cycle_ms;
               end
               flip_go = pending_in || (flip_elapsed_in >= cfg.cycle_ms);

               if (in_dnd_ff && !(cfg.pattern_mode && cfg.ignore_dnd)) begin
                  active_in      = 1'b0;
                  lvl_a_in       = 1'b0;
                  lvl_b_in       = 1'b0;
                  seg_index_in   = '0;
                  repeat_done_in = '0;
                  seg_elapsed_in = '0;
               end else if (cfg.pattern_mode) begin
                  if (seg_index_ff >= n_segs) begin
                     repeat_done_in = repeat_done_ff + BYTE_W'(1);
                     if (repeat_done_in >= cfg.repeat_count) begin
                        done_in = 1'b1;
                     end else begin
                        seg_index_in   = '0;
                        seg_elapsed_in = '0;
                     end
                  end
                  if (done_in) begin
                     active_in      = 1'b0;
                     lvl_a_in       = 1'b0;
                     lvl_b_in       = 1'b0;
                     seg_index_in   = '0;
                     repeat_done_in = '0;
                     seg_elapsed_in = '0;
                  end else begin
                     ring = !seg_index_in[0];
                     if (seg_elapsed_in >= seg_duration(seg_index_in[2:0], cfg.seg_lo,
                                                        cfg.seg_hi)) begin
                        seg_index_in   = seg_index_in + CNT_W'(1);
                        seg_elapsed_in = '0;
                        if (seg_index_in < n_segs) ring = !seg_index_in[0];
                     end
                     if (!ring) begin
                        lvl_a_in = 1'b0;
                        lvl_b_in = 1'b0;
                     end else if (flip_go) begin
                        polarity_in     = !polarity_ff;
                        pending_in      = 1'b0;
                        flip_elapsed_in = '0;
                        lvl_a_in        = !polarity_ff;
                        lvl_b_in        = polarity_ff;
                     end
                  end
               end else begin
                  if (seg_elapsed_in >= seg_duration(3'd0, cfg.seg_lo, cfg.seg_hi)) begin
                     done_in        = 1'b1;
                     active_in      = 1'b0;
                     lvl_a_in       = 1'b0;
                     lvl_b_in       = 1'b0;
                     seg_index_in   = '0;
                     repeat_done_in = '0;
                     seg_elapsed_in = '0;
                  end else if (flip_go) begin
                     polarity_in     = !polarity_ff;
                     pending_in      = 1'b0;
                     flip_elapsed_in = '0;
                     lvl_a_in        = !polarity_ff;
                     lvl_b_in        = polarity_ff;
                  end
               end
            end
         end
         REQ_START: begin
            if (!active_ff) begin
               active_in       = 1'b1;
               seg_index_in    = '0;
               repeat_done_in  = '0;
               seg_elapsed_in  = '0;
               flip_elapsed_in = '0;
               polarity_in     = 1'b0;
               pending_in      = 1'b1;
            end
         end
         REQ_STOP: begin
            if (active_ff) begin
               active_in      = 1'b0;
               lvl_a_in       = 1'b0;
               lvl_b_in       = 1'b0;
               seg_index_in   = '0;
               repeat_done_in = '0;
               seg_elapsed_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_type_ff <= req_ch.req_type;
         in_dnd_ff  <= req_ch.dnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         seg_index_ff    <= '0;
         repeat_done_ff  <= '0;
         seg_elapsed_ff  <= '0;
         flip_elapsed_ff <= '0;
         polarity_ff     <= 1'b0;
         pending_ff      <= 1'b0;
         lvl_a_ff        <= 1'b0;
         lvl_b_ff        <= 1'b0;
      end else if (out_load) begin
         active_ff       <= active_in;
         seg_index_ff    <= seg_index_in;
         repeat_done_ff  <= repeat_done_in;
         seg_elapsed_ff  <= seg_elapsed_in;
         flip_elapsed_ff <= flip_elapsed_in;
         polarity_ff     <= polarity_in;
         pending_ff      <= pending_in;
         lvl_a_ff        <= lvl_a_in;
         lvl_b_ff        <= lvl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         drive_a_ff   <= lvl_a_in;
         drive_b_ff   <= lvl_b_in;
         ringing_ff   <= active_in;
         ring_done_ff <= done_in;
      end
   end

   `RCD_ASSERT_NXT(a_req_held, clock, reset, in_valid_ff && !out_load, in_valid_ff)
   `RCD_ASSERT_IMP(a_idle_quiet, clock, reset, !active_ff, !lvl_a_ff && !lvl_b_ff)
   `RCD_ASSERT(a_no_shoot_through, clock, reset, !(lvl_a_ff && lvl_b_ff))
   `RCD_ASSERT(a_seg_index_range, clock, reset, seg_index_ff <= MAX_SEG_N)
   `RCD_ASSERT_IMP(a_done_ends_ring, clock, reset, out_valid_ff && ring_done_ff,
                   !ringing_ff && !drive_a_ff && !drive_b_ff)

endmodule

@@ sv/ring_cadence_driver_core.sv @@
// Top level of the ring cadence driver: register bank and cadence engine.
//
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   req_type[1:0], dnd
//  rsp_ch   out  valid/ready   drive_a, drive_b, bridge_enable, ringing, ring_done
//  csr_ch   in   valid/ready   index[2:0], wdata[63:0]; ready always high
//
// Each request passes through the request register, then through the state update
// into the response register. One request per cycle is sustained while rsp_ch
// is ready; the state registers update with the response.
// A stalled response holds the request register, which then holds req_ch.ready low.
// Synchronous reset clears all control state and loads the register defaults.
module ring_cadence_driver_core (
   input logic       clock,
   input logic       reset,
   rcd_req_if.sink   req_ch,
   rcd_rsp_if.source rsp_ch,
   rcd_csr_if.sink   csr_ch
);
   import rcd_pkg::*;

   cfg_type cfg;

   rcd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   rcd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

@@ tb/ring_cadence_driver_core_tb.sv @@
// Self-checking testbench for ring_cadence_driver_core: directed and random cadence requests.
`timescale 1ns / 100ps

module ring_cadence_driver_core_tb;
   import rcd_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int HOLD_CYCLES   = 100;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_NS    = 10_000_000;

   typedef struct packed {
      logic drive_a;
      logic drive_b;
      logic bridge_enable;
      logic ringing;
      logic ring_done;
   } bell_out_type;

   logic clock;
   logic reset;

   rcd_req_if req_ch ();
   rcd_rsp_if rsp_ch ();
   rcd_csr_if csr_ch ();

   ring_cadence_driver_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of the registers and cadence state
   cfg_type     regs;
   logic        ring_on;
   logic [3:0]  seg_pos;
   logic [7:0]  plays;
   logic [15:0] seg_ms;
   logic [7:0]  flip_ms;
   logic        polarity;
   logic        first_flip;
   logic        lvl_a;
   logic        lvl_b;

   bell_out_type bell_expect[$];
   int        fail_count = 0;
   int        n_requests = 0;
   int        n_ring_done = 0;
   int        n_writes = 0;
   bit        idling = 1'b1;
   int        hold_ask = 0;
   int        hold_seen = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout, %0d responses still outstanding", $time, bell_expect.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_cadence();
      regs.seg_lo       = 64'd2000;
      regs.seg_hi       = '0;
      regs.seg_count    = 4'd1;
      regs.repeat_count = 8'd1;
      regs.pattern_mode = 1'b0;
      regs.cycle_ms     = 8'd30;
      regs.ignore_dnd   = 1'b0;
      ring_on    = 1'b0;
      seg_pos    = '0;
      plays      = '0;
      seg_ms     = '0;
      flip_ms    = '0;
      polarity   = 1'b0;
      first_flip = 1'b0;
      lvl_a      = 1'b0;
      lvl_b      = 1'b0;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_SEG_LO:     regs.seg_lo = val;
         REG_SEG_HI:     regs.seg_hi = val;
         REG_SEG_COUNT:  regs.seg_count = val[CNT_W-1:0];
         REG_REPEAT_CNT: regs.repeat_count = val[BYTE_W-1:0];
         REG_PATTERN:    regs.pattern_mode = val[0];
         REG_CYCLE_MS:   regs.cycle_ms = val[BYTE_W-1:0];
         REG_IGNORE_DND: regs.ignore_dnd = val[0];
         default: ;
      endcase
   endfunction

   function automatic logic [SEG_W-1:0] seg_len(input logic [2:0] k);
      logic [CSR_DATA_W-1:0] word;
      word = k[2] ? regs.seg_hi : regs.seg_lo;
      return SEG_W'(word >> (16 * k[1:0]));
   endfunction

   function automatic logic [3:0] seg_total();
      if (regs.seg_count == 4'd0) return 4'd1;
      if (regs.seg_count > 4'(MAX_SEGMENTS)) return 4'(MAX_SEGMENTS);
      return regs.seg_count;
   endfunction

   function automatic void stop_ring();
      ring_on = 1'b0;
      lvl_a   = 1'b0;
      lvl_b   = 1'b0;
      seg_pos = '0;
      plays   = '0;
      seg_ms  = '0;
   endfunction

   function automatic void flip_if_due();
      if (first_flip || flip_ms >= regs.cycle_ms) begin
         polarity   = ~polarity;
         first_flip = 1'b0;
         flip_ms    = '0;
         lvl_a      = polarity;
         lvl_b      = ~polarity;
      end
   endfunction

   // one millisecond of cadence; returns 1 on a normal end of the ring
   function automatic logic advance_ms(input logic dnd);
      logic [3:0] n;
      logic       ring;
      if (!ring_on) return 1'b0;
      if (seg_ms != 16'hFFFF) seg_ms++;
      if (flip_ms != 8'hFF) flip_ms++;
      if (first_flip && flip_ms >= regs.cycle_ms) begin
         first_flip = 1'b0;
         flip_ms    = flip_ms - regs.cycle_ms;
      end
      if (dnd && !(regs.pattern_mode && regs.ignore_dnd)) begin
         stop_ring();
         return 1'b0;
      end
      if (regs.pattern_mode) begin
         n = seg_total();
         if (seg_pos >= n) begin
            plays = plays + 8'd1;
            if (plays >= regs.repeat_count) begin
               stop_ring();
               return 1'b1;
            end
            seg_pos = '0;
            seg_ms  = '0;
         end
         ring = ~seg_pos[0];
         if (seg_ms >= seg_len(seg_pos[2:0])) begin
            seg_pos++;
            seg_ms = '0;
            // past the last segment the current one keeps its ring/silent sense
            if (seg_pos < n) ring = ~seg_pos[0];
         end
         if (ring) begin
            flip_if_due();
         end else begin
            lvl_a = 1'b0;
            lvl_b = 1'b0;
         end
      end else begin
         if (seg_ms >= seg_len(3'd0)) begin
            stop_ring();
            return 1'b1;
         end
         flip_if_due();
      end
      return 1'b0;
   endfunction

   function automatic bell_out_type step_cadence(input logic [REQ_TYPE_W-1:0] code,
                                                 input logic dnd);
      bell_out_type o;
      logic      done;
      done = 1'b0;
      case (code)
         REQ_TICK: done = advance_ms(dnd);
         REQ_START: begin
            if (!ring_on) begin
               ring_on    = 1'b1;
               seg_pos    = '0;
               plays      = '0;
               seg_ms     = '0;
               flip_ms    = '0;
               polarity   = 1'b0;
               first_flip = 1'b1;
            end
         end
         REQ_STOP: begin
            if (ring_on) stop_ring();
         end
         default: ;
      endcase
      o.drive_a       = lvl_a;
      o.drive_b       = lvl_b;
      o.bridge_enable = ring_on;
      o.ringing       = ring_on;
      o.ring_done     = done;
      return o;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_bit(input string field, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %b, got %b", $time, field, want, got);
         fail_count++;
      end
   endfunction

   initial reset_cadence();

   always @(posedge clock) begin
      bell_out_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            apply_reg(csr_ch.index, csr_ch.wdata);
            n_writes++;
         end
         if (req_ch.valid && req_ch.ready) begin
            want = step_cadence(req_ch.req_type, req_ch.dnd);
            bell_expect.insert(bell_expect.size(), want);
            n_requests++;
            if (want.ring_done) n_ring_done++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (bell_expect.size() == 0) begin
               $display("%0t: extra response, expected none, got a=%b b=%b en=%b ring=%b done=%b",
                        $time, rsp_ch.drive_a, rsp_ch.drive_b, rsp_ch.bridge_enable,
                        rsp_ch.ringing, rsp_ch.ring_done);
               fail_count++;
            end else begin
               want = bell_expect.pop_front();
               check_bit("drive_a", want.drive_a, rsp_ch.drive_a);
               check_bit("drive_b", want.drive_b, rsp_ch.drive_b);
               check_bit("bridge_enable", want.bridge_enable, rsp_ch.bridge_enable);
               check_bit("ringing", want.ringing, rsp_ch.ringing);
               check_bit("ring_done", want.ring_done, rsp_ch.ring_done);
            end
         end
      end
   end

   // response side: random stall bursts, plus a long hold on demand
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (idling && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // valid stays high after the handshake; the next call or wait_drained decides
   task automatic send_req(input logic [REQ_TYPE_W-1:0] code, input logic dnd);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.dnd      <= dnd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_drained(input int extra);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (bell_expect.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] with_noise(input logic [CSR_DATA_W-1:0] val,
                                                        input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return ({$urandom(), $urandom()} & ~mask) | (val & mask);
   endfunction

   // narrow registers get random upper bits, which the block must drop
   task automatic load_config(input cfg_type c);
      logic [CSR_IDX_W-1:0]  idx[7];
      logic [CSR_DATA_W-1:0] val[7];
      idx = '{REG_SEG_LO, REG_SEG_HI, REG_SEG_COUNT, REG_REPEAT_CNT,
              REG_PATTERN, REG_CYCLE_MS, REG_IGNORE_DND};
      val[0] = c.seg_lo;
      val[1] = c.seg_hi;
      val[2] = with_noise(64'(c.seg_count), CNT_W);
      val[3] = with_noise(64'(c.repeat_count), BYTE_W);
      val[4] = with_noise(64'(c.pattern_mode), 1);
      val[5] = with_noise(64'(c.cycle_ms), BYTE_W);
      val[6] = with_noise(64'(c.ignore_dnd), 1);
      wait_drained(SETTLE_CYCLES);
      for (int k = 0; k < 7; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[k];
         csr_ch.wdata <= val[k];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic cfg_type pick_config(input int kind);
      cfg_type c;
      for (int k = 0; k < 4; k++) begin
         c.seg_lo[16*k +: 16] = 16'($urandom_range(0, 4));
         c.seg_hi[16*k +: 16] = 16'($urandom_range(0, 4));
      end
      c.seg_count    = 4'($urandom_range(0, 15));
      c.repeat_count = 8'($urandom_range(0, 3));
      c.pattern_mode = 1'($urandom_range(0, 1));
      c.cycle_ms     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 4));
      c.ignore_dnd   = 1'($urandom_range(0, 1));
      if (!c.pattern_mode) c.seg_lo[15:0] = 16'($urandom_range(0, 25));
      case (kind)
         1: begin   // everything at its top value; only stop can end a ring
            c.seg_lo = '1; c.seg_hi = '1; c.seg_count = 4'hF; c.repeat_count = 8'hFF;
            c.cycle_ms = 8'hFF; c.pattern_mode = 1'b1; c.ignore_dnd = 1'b1;
         end
         2: begin   // everything zero: one-tick segments, flip every tick
            c.seg_lo = '0; c.seg_hi = '0; c.seg_count = 4'd0; c.repeat_count = 8'd0;
            c.cycle_ms = 8'd0; c.pattern_mode = 1'b1; c.ignore_dnd = 1'b0;
         end
         3: begin
            c.seg_lo = '0; c.seg_hi = '0; c.seg_count = 4'hF; c.repeat_count = 8'hFF;
            c.cycle_ms = 8'd1; c.pattern_mode = 1'b1;
         end
         4: begin
            c.seg_lo = '1; c.cycle_ms = 8'hFF; c.pattern_mode = 1'b0; c.ignore_dnd = 1'b1;
         end
         default: ;
      endcase
      return c;
   endfunction

   // mostly start-then-ticks cadences, with some stops, dnd and junk codes
   task automatic send_cadence_item();
      int r;
      r = $urandom_range(0, 99);
      if (!ring_on && r < 70)
         send_req(REQ_START, 1'($urandom_range(0, 1)));
      else if (r < 3)
         send_req(REQ_STOP, 1'($urandom_range(0, 1)));
      else if (r < 5)
         send_req(REQ_START, 1'($urandom_range(0, 1)));
      else if (r < 7)
         send_req(REQ_UNUSED, 1'($urandom_range(0, 1)));
      else
         send_req(REQ_TICK, ($urandom_range(0, 39) == 0));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_requests();
      // default registers: simple 2000 ms ring
      send_req(REQ_TICK, 1'b1);
      send_req(REQ_STOP, 1'b0);
      send_req(REQ_UNUSED, 1'b1);
      send_req(REQ_START, 1'b0);
      send_req(REQ_START, 1'b1);
      send_req(REQ_TICK, 1'b0);
      send_req(REQ_UNUSED, 1'b0);
      send_req(REQ_TICK, 1'b1);
   endtask

   task automatic test_simple_ring();
      cfg_type c;
      c = pick_config(0);
      c.pattern_mode = 1'b0;
      c.seg_lo = 64'hABCD_1234_5678_0003;
      c.cycle_ms = 8'd2;
      c.ignore_dnd = 1'b1;
      load_config(c);
      send_req(REQ_START, 1'b0);
      repeat (4) send_req(REQ_TICK, 1'b0);
      send_req(REQ_START, 1'b0);
      send_req(REQ_TICK, 1'b0);
      send_req(REQ_STOP, 1'b0);
      send_req(REQ_STOP, 1'b1);
   endtask

   task automatic test_pattern_edges();
      cfg_type c;
      c.seg_lo = {16'd0, 16'd1, 16'd0, 16'd2};
      c.seg_hi = '1;
      c.seg_count = 4'd4;
      c.repeat_count = 8'd0;
      c.pattern_mode = 1'b1;
      c.cycle_ms = 8'd0;
      c.ignore_dnd = 1'b1;
      load_config(c);
      send_req(REQ_START, 1'b1);
      repeat (7) send_req(REQ_TICK, 1'b1);
   endtask

   task automatic test_random_cadence();
      for (int i = 0; i < 10; i++) begin
         load_config(pick_config(i < 5 ? i : 0));
         idling = (i % 4 != 3);
         repeat (150) send_cadence_item();
      end
      idling = 1'b1;
   endtask

   task automatic test_backpressure();
      cfg_type c;
      c = pick_config(0);
      c.pattern_mode = 1'b0;
      c.seg_lo[15:0] = 16'd30;
      c.cycle_ms = 8'd2;
      load_config(c);
      hold_ask++;
      repeat (60) send_cadence_item();
      wait_drained(0);
      repeat (90) send_cadence_item();
   endtask

   task automatic test_streaming();
      idling = 1'b0;
      repeat (2) begin
         load_config(pick_config(0));
         repeat (90) send_cadence_item();
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_TICK;
      req_ch.dnd      <= 1'b0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= REG_SEG_LO;
      csr_ch.wdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_requests();
      test_simple_ring();
      test_pattern_edges();
      test_random_cadence();
      test_backpressure();
      test_streaming();

      wait_drained(2 * SETTLE_CYCLES);
      $display("Ran %0d requests over %0d register writes; %0d rings ended with ring_done.",
               n_requests, n_writes, n_ring_done);
      $display("Covered simple and pattern modes, dnd, stops, junk codes and response stalls.");
      if (fail_count == 0 && bell_expect.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
